@@ design/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/mva_pkg.sv @@
// shared types, codes and sizes of the matrix-vector accumulate block
// no dependencies
package mva_pkg;

  localparam int ROWS   = 1024;
  localparam int ROW_W  = 10;
  localparam int ACC_W  = 48;
  localparam int VAL_W  = 32;
  localparam int ADDR_W = (ROWS > 1) ? (($clog2(ROWS) > ROW_W) ? ROW_W : $clog2(ROWS)) : 1;

  localparam logic [1:0] MODE_ACC  = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              mode;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] mat_value;
    logic signed [VAL_W-1:0] vec_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] result_value;
    logic                    saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic in_load;
    logic rd_en;
    logic mul_en;
    logic wr_en;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       row_ok;
    logic       out_free;
  } status_t;

endpackage

@@ design/mva_ctrl.sv @@
// controller state machine: accept, fetch and multiply, then execute
// depends on mva_pkg for the command and status structs and mode codes
module mva_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mva_pkg::status_t status,
  output mva_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       is_write, is_read;

  assign is_write = status.row_ok &&
                    (status.mode inside {mva_pkg::MODE_ACC, mva_pkg::MODE_LOAD});
  assign is_read  = status.row_ok && (status.mode == mva_pkg::MODE_READ);

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.mul_en = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (is_read) begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.wr_en = is_write;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/mva_dpath.sv @@
// datapath: item register, accumulator memory, multiplier, saturating add, result register
// depends on mva_pkg for payload types, command and status structs
module mva_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  mva_pkg::in_item_t  in_data,
  input  mva_pkg::cmd_t      cmd,
  output mva_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_stall,
  output mva_pkg::out_item_t out_data
);

  // accumulator memory word: saturation mark above the 48-bit value
  logic [mva_pkg::ACC_W:0] acc_mem [mva_pkg::ROWS];

  mva_pkg::in_item_t              item_r;
  logic [mva_pkg::ACC_W:0]        rd_q_r;
  logic signed [2*mva_pkg::VAL_W-1:0] prod_r;
  mva_pkg::out_item_t             out_data_r;
  logic                           out_valid_r, out_valid_nxt;

  logic [mva_pkg::ADDR_W-1:0]     addr;
  logic signed [mva_pkg::ACC_W-1:0] prod_fl, acc_old, acc_sat;
  logic signed [mva_pkg::ACC_W:0] sum;
  logic                           ovf;
  logic [mva_pkg::ACC_W:0]        wr_word;

  assign addr = item_r.row[mva_pkg::ADDR_W-1:0];

  // item register
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      item_r <= in_data;
    end
  end

  // memory read and write, read data registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q_r <= acc_mem[addr];
    end
    if (cmd.wr_en) begin
      acc_mem[addr] <= wr_word;
    end
  end

  // full product registered before the add
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= item_r.mat_value * item_r.vec_value;
    end
  end

  // drop 16 fraction bits (floor), add and clamp; a load takes the sign-extended matrix value
  always_comb begin
    prod_fl = prod_r[2*mva_pkg::VAL_W-1:16];
    acc_old = rd_q_r[mva_pkg::ACC_W-1:0];
    sum     = {acc_old[mva_pkg::ACC_W-1], acc_old} + {prod_fl[mva_pkg::ACC_W-1], prod_fl};
    ovf     = sum[mva_pkg::ACC_W] ^ sum[mva_pkg::ACC_W-1];
    if (!ovf) begin
      acc_sat = sum[mva_pkg::ACC_W-1:0];
    end else if (sum[mva_pkg::ACC_W]) begin
      acc_sat = mva_pkg::ACC_MIN;
    end else begin
      acc_sat = mva_pkg::ACC_MAX;
    end
    if (item_r.mode == mva_pkg::MODE_LOAD) begin
      wr_word = {1'b0, {(mva_pkg::ACC_W-mva_pkg::VAL_W){item_r.mat_value[mva_pkg::VAL_W-1]}},
                 item_r.mat_value};
    end else begin
      wr_word = {rd_q_r[mva_pkg::ACC_W] | ovf, acc_sat};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.result_value <= rd_q_r[mva_pkg::ACC_W-1:0];
      out_data_r.saturated    <= rd_q_r[mva_pkg::ACC_W];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.mode     = item_r.mode;
  assign status.row_ok   = (32'(item_r.row) < 32'(mva_pkg::ROWS));
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

@@ design/matrix_vector_accumulate.sv @@
// top level of the matrix-vector accumulate block
// depends on mva_pkg, mva_ctrl, mva_dpath and assert_macros.svh
//
// Usage:
//  - input channel in_valid/in_stall/in_data carries one beat per item: mode, row,
//    matrix value and vector value. Mode 0 adds floor(mat*vec >> 16) into the row's
//    48-bit accumulator with saturation, mode 1 reads the row, mode 2 loads a start value.
//  - output channel out_valid/out_stall/out_data returns one beat per read item:
//    the accumulator and its saturation mark. Other modes give no beat.
//  - each item passes through accept, memory read plus 32x32 multiply, then
//    add/saturate and write back (or result register load). The single-port
//    accumulator memory and the registered multiplier set these steps.
//  - a new item is accepted only after the previous one has finished its steps.
//  - while the result register holds an unaccepted beat and out_stall is high,
//    a following read item waits in its execute step; in_stall stays high.
//  - reset clears the controller and the output valid; the accumulator memory is not
//    cleared, so a row must be loaded before it is accumulated or read.
//  - mode 3 and rows at or above the row count are dropped with no effect.
`include "assert_macros.svh"

module matrix_vector_accumulate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mva_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mva_pkg::out_item_t out_data
);

  mva_pkg::cmd_t    cmd;
  mva_pkg::status_t status;

  // controller
  mva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  mva_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks on controller and datapath cooperation
  `ASSERT_NEXT(a_accept_fetch, clk, rst_n, in_valid && !in_stall, cmd.rd_en && cmd.mul_en)
  `ASSERT_SAME(a_no_wr_and_out, clk, rst_n, cmd.wr_en, !cmd.out_load)
  `ASSERT_SAME(a_out_from_load, clk, rst_n, $rose(out_valid), $past(cmd.out_load))
  `ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, !out_valid || !out_stall)

endmodule

@@ tb/matrix_vector_accumulate_test.sv @@
// self-checking testbench for the matrix-vector accumulate block
// depends on mva_pkg and matrix_vector_accumulate; predicts every row read and checks
// each output beat: a directed table first, then random column sweeps and stray beats
module matrix_vector_accumulate_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_PCT = 19;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_BEATS = 1900;
  localparam longint SUM_HI = (longint'(1) <<< (mva_pkg::ACC_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct {
    mva_pkg::in_item_t  beat;
    bit                 typed;
    mva_pkg::out_item_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  mva_pkg::in_item_t  in_data = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mva_pkg::out_item_t out_data;

  // shadow copy of the accumulator bank
  logic signed [mva_pkg::ACC_W-1:0] acc_shadow [mva_pkg::ROWS];
  bit                               sat_shadow [mva_pkg::ROWS];
  bit                               row_loaded [mva_pkg::ROWS];
  int                               loaded_rows [$];

  mva_pkg::out_item_t pending_reads [$];
  mva_pkg::out_item_t oldest_read;
  stim_row_t          dir_tbl [$];
  int                 errors = 0;
  int                 quiet_cycles = 0;
  int                 rowbeats = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;

  matrix_vector_accumulate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apply one accepted beat to the shadow bank; returns 1 when a row read is due
  function automatic bit mac_row_update(input mva_pkg::in_item_t b,
                                        output mva_pkg::out_item_t res);
    longint prod;
    longint total;
    int     r;
    res = '0;
    if (b.mode == MODE_SPARE || int'(b.row) >= mva_pkg::ROWS) return 1'b0;
    r = int'(b.row);
    case (b.mode)
      mva_pkg::MODE_ACC: begin
        // product floored to 16 fraction bits, sum clamped to the accumulator range
        prod = (longint'($signed(b.mat_value)) * longint'($signed(b.vec_value))) >>> 16;
        total = longint'(acc_shadow[r]) + prod;
        if (total > SUM_HI) begin
          total = SUM_HI;
          sat_shadow[r] = 1'b1;
        end else if (total < SUM_LO) begin
          total = SUM_LO;
          sat_shadow[r] = 1'b1;
        end
        acc_shadow[r] = total[mva_pkg::ACC_W-1:0];
        return 1'b0;
      end
      mva_pkg::MODE_READ: begin
        res.result_value = acc_shadow[r];
        res.saturated = sat_shadow[r];
        return 1'b1;
      end
      mva_pkg::MODE_LOAD: begin
        total = longint'($signed(b.mat_value));
        acc_shadow[r] = total[mva_pkg::ACC_W-1:0];
        sat_shadow[r] = 1'b0;
        if (!row_loaded[r]) begin
          row_loaded[r] = 1'b1;
          loaded_rows.push_back(r);
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t mk(input logic [1:0] mode, input int row,
                                   input logic [mva_pkg::VAL_W-1:0] mat,
                                   input logic [mva_pkg::VAL_W-1:0] vec,
                                   input bit typed = 1'b0,
                                   input logic [mva_pkg::ACC_W-1:0] val = '0,
                                   input bit sat = 1'b0);
    stim_row_t s;
    s.beat.mode = mode;
    s.beat.row = row[mva_pkg::ROW_W-1:0];
    s.beat.mat_value = mat;
    s.beat.vec_value = vec;
    s.typed = typed;
    s.want.result_value = val;
    s.want.saturated = sat;
    return s;
  endfunction

  // operand mix: full range, small, extremes and values near one
  function automatic logic [mva_pkg::VAL_W-1:0] rand_operand();
    logic [mva_pkg::VAL_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: begin
        v = $urandom_range(32'h000F_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        v = 32'h0001_0000 + $urandom_range(255);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // offer one beat, wait for it to be taken, then maybe idle
  task automatic send_beat(input mva_pkg::in_item_t b, input bit typed,
                           input mva_pkg::out_item_t want);
    mva_pkg::out_item_t predicted;
    bit                 has_result;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_result = mac_row_update(b, predicted);
    if (has_result) pending_reads.push_back(typed ? want : predicted);
    if (b.mode != MODE_SPARE) rowbeats++;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: result beat with none expected: expected none, actual %h/%b",
                 $time, out_data.result_value, out_data.saturated);
        errors++;
      end else begin
        oldest_read = pending_reads.pop_front();
        if (out_data.result_value !== oldest_read.result_value) begin
          $display("%0t: result_value mismatch: expected %h, actual %h",
                   $time, oldest_read.result_value, out_data.result_value);
          errors++;
        end
        if (out_data.saturated !== oldest_read.saturated) begin
          $display("%0t: saturated mismatch: expected %b, actual %b",
                   $time, oldest_read.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    mva_pkg::in_item_t b;
    int                picks [$];
    int                nrows;
    int                ncols;
    int                r;
    bit                hold_done;
    bit                pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;

    // directed table: extremes, floor rounding, both saturation limits, spare mode
    dir_tbl = '{
      mk(mva_pkg::MODE_LOAD, 0, 32'h0000_0000, 32'h0000_0000),
      mk(mva_pkg::MODE_READ, 0, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'h0000_0000_0000, 1'b0),
      mk(mva_pkg::MODE_LOAD, 1023, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
      mk(mva_pkg::MODE_READ, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 48'h0000_7FFF_FFFF, 1'b0),
      mk(mva_pkg::MODE_LOAD, 512, 32'h8000_0000, 32'h0000_0000),
      mk(mva_pkg::MODE_READ, 512, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'hFFFF_8000_0000, 1'b0),
      mk(mva_pkg::MODE_ACC, 0, 32'h8000_0000, 32'h8000_0000),
      mk(mva_pkg::MODE_READ, 0, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'h4000_0000_0000, 1'b0),
      mk(mva_pkg::MODE_ACC, 0, 32'h8000_0000, 32'h8000_0000),
      mk(mva_pkg::MODE_READ, 0, 32'h0000_0000, 32'h0000_0000, 1'b1, mva_pkg::ACC_MAX, 1'b1),
      mk(mva_pkg::MODE_ACC, 0, 32'h0001_0000, 32'hFFFF_0000),
      mk(mva_pkg::MODE_READ, 0, 32'h0000_0000, 32'h0000_0000),
      mk(mva_pkg::MODE_LOAD, 0, 32'h0000_0000, 32'h0000_0000),
      mk(mva_pkg::MODE_ACC, 0, 32'hFFFF_FFFF, 32'h0000_0001),
      mk(mva_pkg::MODE_READ, 0, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0),
      mk(mva_pkg::MODE_ACC, 512, 32'h8000_0000, 32'h7FFF_FFFF),
      mk(mva_pkg::MODE_ACC, 512, 32'h8000_0000, 32'h7FFF_FFFF),
      mk(mva_pkg::MODE_READ, 512, 32'h0000_0000, 32'h0000_0000, 1'b1, mva_pkg::ACC_MIN, 1'b1),
      mk(MODE_SPARE, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      mk(mva_pkg::MODE_READ, 1023, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'h0000_7FFF_FFFF, 1'b0),
      mk(mva_pkg::MODE_ACC, 1023, 32'h0001_0000, 32'h0001_0000),
      mk(mva_pkg::MODE_READ, 1023, 32'h0000_0000, 32'h0000_0000),
      mk(mva_pkg::MODE_LOAD, 1023, 32'hFFFF_FFFF, 32'h0000_0000),
      mk(mva_pkg::MODE_READ, 1023, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].want);

    // random column sweeps with some noise in between
    while (rowbeats < RAND_BEATS) begin
      calm = (rowbeats >= 700 && rowbeats < 1000);
      if (!hold_done && rowbeats >= 300) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && rowbeats >= 1200) begin
        // sender pause until every read has come back
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reads.size() != 0);
        pause_done = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        // load a few rows, sweep several columns into them, read them back
        nrows = $urandom_range(1, 4);
        ncols = $urandom_range(1, 6);
        picks.delete();
        repeat (nrows) begin
          r = $urandom_range(mva_pkg::ROWS - 1);
          picks.push_back(r);
          b.mode = mva_pkg::MODE_LOAD;
          b.row = r[mva_pkg::ROW_W-1:0];
          b.mat_value = rand_operand();
          b.vec_value = $urandom;
          send_beat(b, 1'b0, '0);
        end
        repeat (ncols) begin
          foreach (picks[k]) begin
            b.mode = mva_pkg::MODE_ACC;
            b.row = picks[k][mva_pkg::ROW_W-1:0];
            b.mat_value = rand_operand();
            b.vec_value = rand_operand();
            send_beat(b, 1'b0, '0);
          end
        end
        foreach (picks[k]) begin
          b.mode = mva_pkg::MODE_READ;
          b.row = picks[k][mva_pkg::ROW_W-1:0];
          b.mat_value = $urandom;
          b.vec_value = $urandom;
          send_beat(b, 1'b0, '0);
        end
      end else begin
        // single stray beat; only rows already loaded are accumulated or read
        b.mode = 2'($urandom_range(3));
        b.mat_value = rand_operand();
        b.vec_value = $urandom;
        if (b.mode inside {MODE_SPARE, mva_pkg::MODE_LOAD} || loaded_rows.size() == 0) begin
          if (b.mode != MODE_SPARE) b.mode = mva_pkg::MODE_LOAD;
          b.row = mva_pkg::ROW_W'($urandom_range(mva_pkg::ROWS - 1));
        end else begin
          r = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
          b.row = r[mva_pkg::ROW_W-1:0];
        end
        send_beat(b, 1'b0, '0);
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mva_pkg.sv
design/mva_ctrl.sv
design/mva_dpath.sv
design/matrix_vector_accumulate.sv
tb/matrix_vector_accumulate_test.sv
